// ===== rtl/plef_pkg.sv =====
// shared constants, command and status types for the edge flattener
// used by plef_ctrl, plef_dpath and piecewise_linear_edge_flattener; no dependencies
package plef_pkg;

  // table and number formats
  localparam int MAX_EDGES     = 64;
  localparam int IDX_W         = $clog2(MAX_EDGES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int VAL_W         = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int RES_W         = OUT_FRAC_BITS + 1;
  // (bin index + fraction) numerator width for the final division
  localparam int TOT_W         = IDX_W + OUT_FRAC_BITS;
  localparam int FRAC_STEPS    = OUT_FRAC_BITS + 1;
  localparam int STEP_W        = $clog2(TOT_W);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_EDGE_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] EDGE_COUNT_RESET = CNT_W'(2);

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // table read address source
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_PROBE,
    RD_LO,
    RD_HI
  } rd_sel_t;

  // result source
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_QUO
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    rd_sel_t  rd_sel;
    logic     srch_init;
    logic     srch_probe;
    logic     srch_upd;
    logic     clamp_idx;
    logic     cap_lo;
    logic     cap_diff;
    logic     div_init_frac;
    logic     clr_quo;
    logic     div_init_total;
    logic     div_step;
    logic     res_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic x_le_edge;
    logic x_ge_edge;
    logic count_zero;
    logic den_pos;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/plef_dpath.sv =====
// datapath: edge memory, search registers, shared restoring divider, output register
// depends on plef_pkg; sequenced by plef_ctrl
module plef_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  plef_pkg::dp_cmd_t                cmd,
  output plef_pkg::dp_stat_t               stat,
  input  logic                             in_accept,
  input  logic                             in_kind,
  input  logic [plef_pkg::IDX_W-1:0]       in_edge_slot,
  input  logic signed [plef_pkg::VAL_W-1:0] in_value_in,
  input  logic [plef_pkg::CNT_W-1:0]       edge_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plef_pkg::RES_W-1:0]       out_mapped_fraction
);
  import plef_pkg::*;

  logic signed [VAL_W-1:0] edge_mem [MAX_EDGES];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] x_r;
  logic signed [VAL_W-1:0] lo_r;
  logic signed [VAL_W:0]   den_r;
  logic signed [VAL_W:0]   num_r;
  logic [CNT_W-1:0]        first_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        probe_r;
  logic [IDX_W-1:0]        idx_r;
  logic [VAL_W-1:0]        rem_r;
  logic [VAL_W-1:0]        dsr_r;
  logic [TOT_W-1:0]        dvd_r;
  logic [TOT_W-1:0]        quo_r;
  logic                    div_head_r;
  logic                    out_valid_r;
  logic [RES_W-1:0]        out_data_r;

  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]        n_m1;
  logic [CNT_W-1:0]        half;
  logic [CNT_W-1:0]        probe_sum;
  logic [IDX_W-1:0]        probe_nxt;
  logic                    edge_lt_x;
  logic signed [VAL_W:0]   num_c;
  logic [VAL_W:0]          trial;
  logic [VAL_W:0]          diff;
  logic                    ge;

  // effective edge count, held in 2..MAX_EDGES
  always_comb begin
    if (edge_count < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (edge_count > CNT_W'(MAX_EDGES)) begin
      n_eff = CNT_W'(MAX_EDGES);
    end else begin
      n_eff = edge_count;
    end
  end
  assign n_m1 = n_eff - CNT_W'(1);

  // next probe of the lower-bound search
  assign half      = count_r >> 1;
  assign probe_sum = first_r + half;
  assign probe_nxt = probe_sum[IDX_W-1:0];

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_LAST:  rd_addr = n_m1[IDX_W-1:0];
      RD_PROBE: rd_addr = probe_nxt;
      RD_LO:    rd_addr = idx_r - IDX_W'(1);
      RD_HI:    rd_addr = idx_r;
      default:  rd_addr = '0;
    endcase
  end

  // edge memory: write on a load word, registered read every cycle
  always_ff @(posedge clk) begin
    if (in_accept && in_kind == KIND_LOAD) begin
      edge_mem[in_edge_slot] <= in_value_in;
    end
    rd_data_r <= edge_mem[rd_addr];
  end

  // argument capture
  always_ff @(posedge clk) begin
    if (in_accept && in_kind == KIND_EVAL) begin
      x_r <= in_value_in;
    end
  end

  assign edge_lt_x = rd_data_r < x_r;

  // search state and bin index clamp
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      first_r <= '0;
      count_r <= n_eff;
    end else if (cmd.srch_upd) begin
      if (edge_lt_x) begin
        first_r <= CNT_W'(probe_r) + CNT_W'(1);
        count_r <= count_r - half - CNT_W'(1);
      end else begin
        count_r <= half;
      end
    end
    if (cmd.srch_probe) begin
      probe_r <= probe_nxt;
    end
    if (cmd.clamp_idx) begin
      if (first_r == '0) begin
        idx_r <= IDX_W'(1);
      end else if (first_r > n_m1) begin
        idx_r <= n_m1[IDX_W-1:0];
      end else begin
        idx_r <= first_r[IDX_W-1:0];
      end
    end
  end

  // bin width and offset into the bin, both 33 bits signed
  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      lo_r <= rd_data_r;
    end
    if (cmd.cap_diff) begin
      den_r <= {rd_data_r[VAL_W-1], rd_data_r} - {lo_r[VAL_W-1], lo_r};
      num_r <= {x_r[VAL_W-1], x_r} - {lo_r[VAL_W-1], lo_r};
    end
  end

  // offset clamped into 0..den
  always_comb begin
    if (num_r[VAL_W]) begin
      num_c = '0;
    end else if (num_r > den_r) begin
      num_c = den_r;
    end else begin
      num_c = num_r;
    end
  end

  // one restoring division step; the first fraction step compares without a shift
  assign trial = div_head_r ? {1'b0, rem_r} : {rem_r, dvd_r[TOT_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init_frac) begin
      rem_r      <= num_c[VAL_W-1:0];
      dsr_r      <= den_r[VAL_W-1:0];
      dvd_r      <= '0;
      quo_r      <= '0;
      div_head_r <= 1'b1;
    end else if (cmd.clr_quo) begin
      quo_r <= '0;
    end else if (cmd.div_init_total) begin
      rem_r      <= '0;
      dsr_r      <= VAL_W'(n_m1);
      dvd_r      <= {idx_r - IDX_W'(1), {OUT_FRAC_BITS{1'b0}}} + TOT_W'(quo_r[RES_W-1:0]);
      quo_r      <= '0;
      div_head_r <= 1'b0;
    end else if (cmd.div_step) begin
      rem_r      <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      quo_r      <= {quo_r[TOT_W-2:0], ge};
      dvd_r      <= {dvd_r[TOT_W-2:0], 1'b0};
      div_head_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ZERO: out_data_r <= '0;
        RES_ONE:  out_data_r <= RES_W'(1) << OUT_FRAC_BITS;
        default:  out_data_r <= quo_r[RES_W-1:0];
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mapped_fraction = out_data_r;

  // status back to the controller
  assign stat.x_le_edge  = x_r <= rd_data_r;
  assign stat.x_ge_edge  = x_r >= rd_data_r;
  assign stat.count_zero = count_r == '0;
  assign stat.den_pos    = !den_r[VAL_W] && (den_r != '0);
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== rtl/plef_ctrl.sv =====
// controller: sequences search, bin fetch, fraction and scale divisions
// depends on plef_pkg; drives plef_dpath through dp_cmd_t
module plef_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic               in_kind,
  input  plef_pkg::dp_stat_t stat,
  output plef_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import plef_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_CHKL,
    S_PROBE,
    S_CMP,
    S_LOAD_LO,
    S_LOAD_HI,
    S_DIFF,
    S_CLAMP,
    S_DIV_FRAC,
    S_TOT_INIT,
    S_DIV_TOT,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  res_sel_t          res_sel_r, res_sel_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    res_sel_nxt = res_sel_r;
    cmd         = '0;
    cmd.rd_sel  = RD_ZERO;
    cmd.res_sel = res_sel_r;
    unique case (state_r)
      S_IDLE: begin
        // edge 0 is read every idle cycle
        if (in_accept && in_kind == KIND_EVAL) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        cmd.rd_sel = RD_LAST;
        if (stat.x_le_edge) begin
          res_sel_nxt = RES_ZERO;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_CHKL;
        end
      end
      S_CHKL: begin
        if (stat.x_ge_edge) begin
          res_sel_nxt = RES_ONE;
          state_nxt   = S_FINISH;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.count_zero) begin
          cmd.clamp_idx = 1'b1;
          state_nxt     = S_LOAD_LO;
        end else begin
          cmd.rd_sel     = RD_PROBE;
          cmd.srch_probe = 1'b1;
          state_nxt      = S_CMP;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_PROBE;
      end
      S_LOAD_LO: begin
        cmd.rd_sel = RD_LO;
        state_nxt  = S_LOAD_HI;
      end
      S_LOAD_HI: begin
        cmd.rd_sel = RD_HI;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        cmd.cap_diff = 1'b1;
        state_nxt    = S_CLAMP;
      end
      S_CLAMP: begin
        // empty or reversed bin gives zero fraction
        if (stat.den_pos) begin
          cmd.div_init_frac = 1'b1;
          step_nxt          = STEP_W'(FRAC_STEPS - 1);
          state_nxt         = S_DIV_FRAC;
        end else begin
          cmd.clr_quo = 1'b1;
          state_nxt   = S_TOT_INIT;
        end
      end
      S_DIV_FRAC: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_TOT_INIT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_TOT_INIT: begin
        cmd.div_init_total = 1'b1;
        step_nxt           = STEP_W'(TOT_W - 1);
        state_nxt          = S_DIV_TOT;
      end
      S_DIV_TOT: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          res_sel_nxt = RES_QUO;
          state_nxt   = S_FINISH;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      res_sel_r <= RES_ZERO;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      res_sel_r <= res_sel_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== rtl/piecewise_linear_edge_flattener.sv =====
// top level: configuration registers, controller and datapath of the edge flattener
// depends on plef_pkg, plef_ctrl and plef_dpath
//
//  port group   direction  handshake        word
//  in_*         in         valid / stall    kind, edge slot, Q16.16 value
//  out_*        out        valid / stall    Q1.16 mapped fraction
//  p*           in / out   apb, pready = 1  edge_count at byte address 0
//
// a load word produces nothing and leaves the input open; the next word is taken at once
// an evaluate word gives zero at or below the first edge and one at or above the last;
// otherwise a lower-bound search through the single read port of the edge memory finds
// the bin, and two serial restoring divisions give the fraction and then scale it; the
// fraction division is skipped for an empty or reversed bin
// a finished result waits in the output register while the next word is accepted; a
// stalled result holds the controller in its last state until the register frees
// reset is synchronous and clears control state and edge_count (to 2), not the edge memory
module piecewise_linear_edge_flattener (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [plef_pkg::IDX_W-1:0]          in_edge_slot,
  input  logic signed [plef_pkg::VAL_W-1:0]   in_value_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [plef_pkg::RES_W-1:0]          out_mapped_fraction,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [plef_pkg::ADDR_W-1:0]         paddr,
  input  logic [plef_pkg::DATA_W-1:0]         pwdata,
  output logic [plef_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import plef_pkg::*;

  logic             in_accept;
  logic             busy;
  logic [CNT_W-1:0] edge_count_r;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // input closed while busy and while reset is held
  assign in_stall  = busy || !rst_n;
  assign in_accept = in_valid && !in_stall;

  // register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= EDGE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EDGE_COUNT) begin
      edge_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_EDGE_COUNT) ? DATA_W'(edge_count_r) : '0;

  // controller
  plef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // datapath
  plef_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_accept           (in_accept),
    .in_kind             (in_kind),
    .in_edge_slot        (in_edge_slot),
    .in_value_in         (in_value_in),
    .edge_count          (edge_count_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mapped_fraction (out_mapped_fraction)
  );

  // an evaluate word closes the input until its result is registered
  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_EVAL) |=> in_stall)
    else $error("input open right after an evaluate word");

  // a load word never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_LOAD && !out_valid && !busy) |=> !out_valid)
    else $error("result appeared after a load word");

  // the result never exceeds one
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mapped_fraction <= (RES_W'(1) << OUT_FRAC_BITS)))
    else $error("mapped fraction above one");

  // a new result is registered only when the previous one leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

endmodule
